// ===== rtl/plf_pkg.sv =====
package plf_pkg;

  // Default coordinate width of the point and light positions.
  localparam int COORD_BITS_DEF = 16;

  // Q16 constants: 1.0 is 65536.
  localparam logic [16:0] ONE_Q16      = 17'd65536;
  localparam logic [16:0] BAKED_MIN    = 17'd6554;
  localparam logic [16:0] AMB_BASE     = 17'd19661;
  localparam logic [16:0] AMB_SPAN     = 17'd45875;
  localparam logic [16:0] NO_SECTOR    = 17'd45875;
  localparam logic [24:0] RECIP_255    = 25'd16843010;
  localparam logic [7:0]  ROUND_255    = 8'd127;
  localparam logic [9:0]  LIT_DYN_GAIN = 10'd765;
  localparam logic [27:0] LIT_ROUND    = 28'd131072;
  localparam logic [24:0] DYN_ROUND    = 25'd32768;

  // Iterative unit sizes.
  localparam int RAD_BITS  = 15;
  localparam int ROOT_BITS = 31;
  localparam int QUO_BITS  = 16;

  typedef enum logic [1:0] {
    REQ_HEADER = 2'd0,
    REQ_BAKED  = 2'd1,
    REQ_STACK  = 2'd2,
    REQ_FINISH = 2'd3
  } req_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DX, S_DY, S_DZ, S_RR, S_CMP, S_SQRT, S_DIV, S_INT, S_IREG,
    S_CM, S_RC, S_ADD, S_FA, S_FR, S_FS, S_LB, S_LA, S_LS, S_OUT
  } state_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

  typedef enum logic [2:0] {
    KIND_WALL, KIND_FLOOR, KIND_CEILING, KIND_WATER, KIND_LAVA, KIND_PORTAL
  } kind_t;

  function automatic rgba_t base_color(input logic [2:0] kind);
    rgba_t c;
    case (kind)
      KIND_FLOOR:   c = '{r: 8'd115, g: 8'd107, b: 8'd97,  a: 8'd255};
      KIND_CEILING: c = '{r: 8'd77,  g: 8'd71,  b: 8'd64,  a: 8'd255};
      KIND_WATER:   c = '{r: 8'd38,  g: 8'd77,  b: 8'd140, a: 8'd204};
      KIND_LAVA:    c = '{r: 8'd179, g: 8'd51,  b: 8'd13,  a: 8'd255};
      KIND_PORTAL:  c = '{r: 8'd26,  g: 8'd26,  b: 8'd26,  a: 8'd77};
      default:      c = '{r: 8'd140, g: 8'd128, b: 8'd107, a: 8'd255};
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/plf_req_if.sv =====
interface plf_req_if #(
  parameter int COORD_BITS = plf_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;
  logic [14:0]                  radius;
  logic [7:0]                   brightness;
  logic [7:0]                   red;
  logic [7:0]                   green;
  logic [7:0]                   blue;
  logic [2:0]                   face_kind;
  logic [8:0]                   ambient;
  logic                         no_light;

  modport source (
    output valid, req_type, pos_x, pos_y, pos_z, radius, brightness,
           red, green, blue, face_kind, ambient, no_light,
    input  ready
  );
  modport sink (
    input  valid, req_type, pos_x, pos_y, pos_z, radius, brightness,
           red, green, blue, face_kind, ambient, no_light,
    output ready
  );
endinterface

interface plf_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] lit_red;
  logic [7:0] lit_green;
  logic [7:0] lit_blue;
  logic [7:0] lit_alpha;
  logic [7:0] dyn_red;
  logic [7:0] dyn_green;
  logic [7:0] dyn_blue;

  modport source (
    output valid, lit_red, lit_green, lit_blue, lit_alpha, dyn_red, dyn_green, dyn_blue,
    input  ready
  );
  modport sink (
    input  valid, lit_red, lit_green, lit_blue, lit_alpha, dyn_red, dyn_green, dyn_blue,
    output ready
  );
endinterface

// ===== rtl/plf_sqrt.sv =====
module plf_sqrt #(
  parameter int ROOT_W = plf_pkg::ROOT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [2*ROOT_W-1:0]   radicand,
  output logic                  done,
  output logic [ROOT_W-1:0]     root
);
  localparam int RMW = ROOT_W + 1;
  localparam int CNW = $clog2(ROOT_W + 1);

  logic [2*ROOT_W-1:0] rad;
  logic [RMW-1:0]      rem;
  logic [CNW-1:0]      cnt;
  logic                busy;
  logic [RMW+1:0]      rem_sh;
  logic [RMW+1:0]      trial;
  logic                fits;

  // One result bit per cycle: two radicand bits move into the remainder.
  assign rem_sh = {rem, rad[2*ROOT_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNW'(ROOT_W);
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad  <= {rad[2*ROOT_W-3:0], 2'b00};
        rem  <= fits ? RMW'(rem_sh - trial) : RMW'(rem_sh);
        root <= {root[ROOT_W-2:0], fits};
        cnt  <= cnt - 1'b1;
        if (cnt == CNW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/plf_div.sv =====
module plf_div #(
  parameter int QW = plf_pkg::QUO_BITS,
  parameter int DW = plf_pkg::RAD_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [QW+DW-1:0] dividend,
  input  logic [DW-1:0]    divisor,
  output logic             done,
  output logic [QW-1:0]    quotient
);
  localparam int CNW = $clog2(QW + 1);

  // The upper part of the dividend is below the divisor, so only the low
  // bits produce quotient bits.
  logic [DW-1:0] rem;
  logic [QW-1:0] low;
  logic [DW-1:0] dvs;
  logic [CNW-1:0] cnt;
  logic          busy;
  logic [DW:0]   t;
  logic          ge;

  assign t  = {rem, low[QW-1]};
  assign ge = t >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CNW'(QW);
        rem      <= dividend[QW+DW-1:QW];
        low      <= dividend[QW-1:0];
        dvs      <= divisor;
        quotient <= '0;
      end else if (busy) begin
        rem      <= ge ? DW'(t - {1'b0, dvs}) : DW'(t);
        low      <= {low[QW-2:0], 1'b0};
        quotient <= {quotient[QW-2:0], ge};
        cnt      <= cnt - 1'b1;
        if (cnt == CNW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/point_light_face_shader.sv =====
// Point light face shader. Requests arrive in runs: a header request latches
// the face point, face kind, sector ambient and no-light bit and clears the
// dynamic light; on a lit face each baked or stack light request adds
// that light's colour, scaled by a linear falloff over its radius and by
// its brightness, to three saturating Q16 accumulators; a finish request
// returns one result with the lit colour and the dynamic light alone.
// A light that misses the point skips the square root and the divide; for
// one that reaches it the square root is found one bit per cycle and the
// falloff quotient one bit per cycle, and the rest is three squarings,
// the radius squared, the intensity and three colour channels on a single
// shared multiplier. A finish request uses that multiplier too, but not on
// a no-light face, and then waits only if the previous result has not
// been taken. One request is worked on at a time.
module point_light_face_shader #(
  parameter int COORD_BITS = plf_pkg::COORD_BITS_DEF
) (
  input logic     clk,
  input logic     rst,
  plf_req_if.sink req,
  plf_res_if.source res
);
  localparam int CW  = COORD_BITS;
  localparam int MW  = (CW + 1 > 25) ? CW + 1 : 25;
  localparam int PW  = 2 * MW;
  localparam int D2W = 2 * CW + 2;
  localparam int RW  = plf_pkg::RAD_BITS;
  localparam int SW  = plf_pkg::ROOT_BITS;
  localparam int QW  = plf_pkg::QUO_BITS;

  plf_pkg::state_t state, state_next;

  // Held face state.
  logic signed [CW-1:0] point_x, point_y, point_z;
  logic [2:0]           kind_held;
  logic [8:0]           ambient_held;
  logic                 unlit_held;
  logic [16:0]          acc [3];

  // Current light.
  logic signed [CW-1:0] lx, ly, lz;
  logic [RW-1:0]        lrad;
  logic [16:0]          bright;
  logic [7:0]           lcol [3];

  // Working registers.
  logic [D2W-1:0] d2;
  logic [PW-1:0]  prod;
  logic [16:0]    inten;
  logic [16:0]    scale;
  logic [25:0]    lsum;
  logic [1:0]     ch;
  logic [7:0]     res_lit [3];
  logic [7:0]     res_dyn [3];

  logic [MW-1:0]  mul_a, mul_b;
  logic           accept;
  logic           sqrt_start, sqrt_done, div_start, div_done;
  logic [SW-1:0]  root;
  logic [QW-1:0]  quo;
  logic           in_range;
  logic           out_free;

  plf_pkg::rgba_t base;
  logic [7:0]     base_ch;

  assign accept   = req.valid && req.ready;
  assign out_free = !res.valid || res.ready;
  assign base     = plf_pkg::base_color(kind_held);

  always_comb begin
    case (ch)
      2'd0:    base_ch = base.r;
      2'd1:    base_ch = base.g;
      default: base_ch = base.b;
    endcase
  end

  // Distance components against the held point, as magnitudes.
  logic signed [CW:0] dx, dy, dz;
  logic [CW:0]        adx, ady, adz;
  assign dx  = {lx[CW-1], lx} - {point_x[CW-1], point_x};
  assign dy  = {ly[CW-1], ly} - {point_y[CW-1], point_y};
  assign dz  = {lz[CW-1], lz} - {point_z[CW-1], point_z};
  assign adx = dx[CW] ? (CW+1)'(-dx) : (CW+1)'(dx);
  assign ady = dy[CW] ? (CW+1)'(-dy) : (CW+1)'(dy);
  assign adz = dz[CW] ? (CW+1)'(-dz) : (CW+1)'(dz);

  assign in_range = PW'(d2) < prod;

  // Brightness in Q16. Baked: b/96 as b*2048/3, with b split by three
  // into a quotient and a remainder, then clamped to [0.10, 1.0].
  // Stack: b/255 rounded, which is 257*b plus one for the upper half.
  logic [15:0] b171;
  logic [6:0]  b_q3;
  logic [1:0]  b_r3;
  logic [17:0] baked_raw;
  logic [16:0] baked_q16, stack_q16, bright_in;
  logic [10:0] r3_frac;
  assign b171 = 16'(req.brightness) * 16'd171;
  assign b_q3 = b171[15:9];
  assign b_r3 = 2'(req.brightness - 8'(b_q3) * 8'd3);
  always_comb begin
    case (b_r3)
      2'd1:    r3_frac = 11'd682;
      2'd2:    r3_frac = 11'd1365;
      default: r3_frac = 11'd0;
    endcase
  end
  assign baked_raw = {b_q3, 11'b0} + 18'(r3_frac);
  assign baked_q16 = (baked_raw >= 18'(plf_pkg::ONE_Q16)) ? plf_pkg::ONE_Q16 :
                     (baked_raw < 18'(plf_pkg::BAKED_MIN)) ? plf_pkg::BAKED_MIN :
                     17'(baked_raw);
  assign stack_q16 = 17'(17'(req.brightness) * 17'd257) + 17'(req.brightness[7]);
  assign bright_in = (req.req_type == plf_pkg::REQ_BAKED) ? baked_q16 : stack_q16;

  // Accumulator step: add round(c*I/255) through the reciprocal product.
  logic [16:0] add_q;
  logic [17:0] add_sum;
  assign add_q   = prod[48:32];
  assign add_sum = {1'b0, acc[ch]} + {1'b0, add_q};

  // Finish step for one channel.
  logic [27:0] lit_total;
  logic [9:0]  lit_v;
  logic [24:0] dyn_total;
  logic [8:0]  dyn_v;
  assign lit_total = 28'(lsum) + 28'(prod[26:0]) + plf_pkg::LIT_ROUND;
  assign lit_v     = lit_total[27:18];
  assign dyn_total = 25'({acc[ch], 8'b0}) - 25'(acc[ch]) + plf_pkg::DYN_ROUND;
  assign dyn_v     = dyn_total[24:16];

  plf_sqrt #(.ROOT_W(SW)) u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start),
    .radicand({30'(d2), 32'b0}), .done(sqrt_done), .root(root)
  );

  plf_div #(.QW(QW), .DW(RW)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(root), .divisor(lrad), .done(div_done), .quotient(quo)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      plf_pkg::S_IDLE: begin
        if (accept) begin
          unique case (plf_pkg::req_t'(req.req_type)) inside
            plf_pkg::REQ_HEADER: state_next = plf_pkg::S_IDLE;
            plf_pkg::REQ_BAKED, plf_pkg::REQ_STACK:
              state_next = unlit_held ? plf_pkg::S_IDLE : plf_pkg::S_DX;
            plf_pkg::REQ_FINISH:
              state_next = unlit_held ? plf_pkg::S_OUT : plf_pkg::S_FA;
          endcase
        end
      end
      plf_pkg::S_DX:   state_next = plf_pkg::S_DY;
      plf_pkg::S_DY:   state_next = plf_pkg::S_DZ;
      plf_pkg::S_DZ:   state_next = plf_pkg::S_RR;
      plf_pkg::S_RR:   state_next = plf_pkg::S_CMP;
      plf_pkg::S_CMP:  state_next = in_range ? plf_pkg::S_SQRT : plf_pkg::S_IDLE;
      plf_pkg::S_SQRT: if (sqrt_done) state_next = plf_pkg::S_DIV;
      plf_pkg::S_DIV:  if (div_done) state_next = plf_pkg::S_INT;
      plf_pkg::S_INT:  state_next = plf_pkg::S_IREG;
      plf_pkg::S_IREG: state_next = plf_pkg::S_CM;
      plf_pkg::S_CM:   state_next = plf_pkg::S_RC;
      plf_pkg::S_RC:   state_next = plf_pkg::S_ADD;
      plf_pkg::S_ADD:  state_next = (ch == 2'd2) ? plf_pkg::S_IDLE : plf_pkg::S_CM;
      plf_pkg::S_FA:   state_next = plf_pkg::S_FR;
      plf_pkg::S_FR:   state_next = plf_pkg::S_FS;
      plf_pkg::S_FS:   state_next = plf_pkg::S_LB;
      plf_pkg::S_LB:   state_next = plf_pkg::S_LA;
      plf_pkg::S_LA:   state_next = plf_pkg::S_LS;
      plf_pkg::S_LS:   state_next = (ch == 2'd2) ? plf_pkg::S_OUT : plf_pkg::S_LB;
      plf_pkg::S_OUT:  if (out_free) state_next = plf_pkg::S_IDLE;
      default:         state_next = plf_pkg::S_IDLE;
    endcase
  end

  // Handshake, unit starts and operands of the shared multiplier.
  always_comb begin
    req.ready  = (state == plf_pkg::S_IDLE);
    sqrt_start = (state == plf_pkg::S_CMP) && in_range;
    div_start  = (state == plf_pkg::S_SQRT) && sqrt_done;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state) inside
      plf_pkg::S_DX: begin mul_a = MW'(adx); mul_b = MW'(adx); end
      plf_pkg::S_DY: begin mul_a = MW'(ady); mul_b = MW'(ady); end
      plf_pkg::S_DZ: begin mul_a = MW'(adz); mul_b = MW'(adz); end
      plf_pkg::S_RR: begin mul_a = MW'(lrad); mul_b = MW'(lrad); end
      plf_pkg::S_INT: begin
        mul_a = MW'(plf_pkg::ONE_Q16 - 17'(quo));
        mul_b = MW'(bright);
      end
      plf_pkg::S_CM: begin mul_a = MW'(lcol[ch]); mul_b = MW'(inten); end
      plf_pkg::S_RC, plf_pkg::S_FR: begin
        mul_a = MW'(prod[24:0] + 25'(plf_pkg::ROUND_255));
        mul_b = MW'(plf_pkg::RECIP_255);
      end
      plf_pkg::S_FA: begin mul_a = MW'(ambient_held[7:0]); mul_b = MW'(plf_pkg::AMB_SPAN); end
      plf_pkg::S_LB: begin mul_a = MW'(base_ch); mul_b = MW'(scale); end
      plf_pkg::S_LA: begin mul_a = MW'(acc[ch]); mul_b = MW'(plf_pkg::LIT_DYN_GAIN); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= plf_pkg::S_IDLE;
      point_x      <= '0;
      point_y      <= '0;
      point_z      <= '0;
      kind_held    <= '0;
      ambient_held <= '0;
      unlit_held   <= 1'b0;
      acc[0]       <= '0;
      acc[1]       <= '0;
      acc[2]       <= '0;
      res.valid    <= 1'b0;
      ch           <= '0;
    end else begin
      state <= state_next;
      prod  <= mul_a * mul_b;
      // The result register loads when it is empty or being taken.
      if (state == plf_pkg::S_OUT && out_free) res.valid <= 1'b1;
      else if (res.ready) res.valid <= 1'b0;

      unique case (state) inside
        plf_pkg::S_IDLE: begin
          ch <= '0;
          if (accept) begin
            if (req.req_type == plf_pkg::REQ_HEADER) begin
              point_x      <= req.pos_x;
              point_y      <= req.pos_y;
              point_z      <= req.pos_z;
              kind_held    <= req.face_kind;
              ambient_held <= req.ambient;
              unlit_held   <= req.no_light;
              acc[0]       <= '0;
              acc[1]       <= '0;
              acc[2]       <= '0;
            end else if (req.req_type == plf_pkg::REQ_FINISH) begin
              // A no-light face shows its base colour and no dynamic light.
              res_lit[0] <= base.r;
              res_lit[1] <= base.g;
              res_lit[2] <= base.b;
              res_dyn[0] <= '0;
              res_dyn[1] <= '0;
              res_dyn[2] <= '0;
            end else begin
              lx      <= req.pos_x;
              ly      <= req.pos_y;
              lz      <= req.pos_z;
              lrad    <= (req.radius == '0) ? RW'(1) : req.radius;
              bright  <= bright_in;
              lcol[0] <= req.red;
              lcol[1] <= req.green;
              lcol[2] <= req.blue;
            end
          end
        end
        plf_pkg::S_DY:   d2 <= D2W'(prod);
        plf_pkg::S_DZ,
        plf_pkg::S_RR:   d2 <= d2 + D2W'(prod);
        plf_pkg::S_IREG: inten <= prod[32:16];
        plf_pkg::S_ADD: begin
          acc[ch] <= (add_sum > 18'(plf_pkg::ONE_Q16)) ? plf_pkg::ONE_Q16 : 17'(add_sum);
          ch      <= ch + 2'd1;
        end
        plf_pkg::S_FS: begin
          // Ambient above 255 means the face has no sector.
          scale <= ambient_held[8] ? plf_pkg::NO_SECTOR :
                   17'(plf_pkg::AMB_BASE + prod[48:32]);
          ch    <= '0;
        end
        plf_pkg::S_LA: lsum <= {prod[23:0], 2'b00};
        plf_pkg::S_LS: begin
          res_lit[ch] <= (lit_v > 10'd255) ? 8'd255 : lit_v[7:0];
          res_dyn[ch] <= (dyn_v > 9'd255) ? 8'd255 : dyn_v[7:0];
          ch          <= ch + 2'd1;
        end
        plf_pkg::S_OUT: begin
          if (out_free) begin
            res.lit_red   <= res_lit[0];
            res.lit_green <= res_lit[1];
            res.lit_blue  <= res_lit[2];
            res.lit_alpha <= base.a;
            res.dyn_red   <= res_dyn[0];
            res.dyn_green <= res_dyn[1];
            res.dyn_blue  <= res_dyn[2];
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Saturation keeps every accumulator at or below 1.0.
  a_acc_bound: assert property (@(posedge clk) disable iff (rst)
    acc[0] <= plf_pkg::ONE_Q16 && acc[1] <= plf_pkg::ONE_Q16 && acc[2] <= plf_pkg::ONE_Q16)
    else $error("accumulator above 1.0");

  // A header request clears the dynamic light.
  a_hdr_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && req.req_type == plf_pkg::REQ_HEADER) |=>
      (acc[0] == '0 && acc[1] == '0 && acc[2] == '0))
    else $error("header did not clear accumulators");

  // A light in range has a squared distance that fits the root unit.
  a_d2_fits: assert property (@(posedge clk) disable iff (rst)
    sqrt_start |-> ((PW'(d2) >> 30) == '0))
    else $error("squared distance too wide for root unit");

  // The root unit only finishes while the sequencer waits for it.
  a_sqrt_wait: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> state == plf_pkg::S_SQRT)
    else $error("root finished outside its wait state");
`endif

endmodule
